/* sv/ioerb_pkg.sv */
// ---------------------------------------------------------------------------
// ioerb_pkg
// Shared types and constants for the in-order event reorder buffer.
// ---------------------------------------------------------------------------
package ioerb_pkg;

  // Field widths
  localparam int ID_W     = 16;
  localparam int KIND_W   = 8;
  localparam int HANDLE_W = 16;

  // Store geometry
  localparam int HOLD_DEPTH  = 32;
  localparam int IDX_W       = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CNT_W       = $clog2(HOLD_DEPTH + 1);
  localparam int MAX_RESULTS = 33;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

  // Half of the id space, for the newer test
  localparam logic [ID_W-1:0] HALF_RANGE = 16'h8000;

  // One held event
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     id;
  } slot_t;

  // One delivered event
  typedef struct packed {
    logic                last;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
  } result_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic [ID_W-1:0]       expected_id;
    logic [CNT_W-1:0]      held_count;
    logic [HOLD_DEPTH-1:0] slot_valid;
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_PUSH = 4'b0100,
    ST_LAST = 4'b1000
  } state_t;

endpackage

/* sv/ioerb_slot_ram.sv */
// ---------------------------------------------------------------------------
// ioerb_slot_ram
// Slot store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ioerb_slot_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ioerb_pkg::IDX_W-1:0] wr_addr,
  input  ioerb_pkg::slot_t           wr_data,
  input  logic                       rd_en,
  input  logic [ioerb_pkg::IDX_W-1:0] rd_addr,
  output ioerb_pkg::slot_t           rd_data
);
  import ioerb_pkg::*;

  slot_t mem [HOLD_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ioerb_seq.sv */
// ---------------------------------------------------------------------------
// ioerb_seq
// Sequencer: decides in-order / newer / old, scans the slot store one entry
// per cycle through a shared id comparator, inserts and drains held events.
// ---------------------------------------------------------------------------
module ioerb_seq (
  input  logic                          clk,
  input  logic                          rst,
  // Input events
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ioerb_pkg::slot_t              in_event,
  // Slot store
  output logic                          ram_wr_en,
  output logic [ioerb_pkg::IDX_W-1:0]   ram_wr_addr,
  output ioerb_pkg::slot_t              ram_wr_data,
  output logic                          ram_rd_en,
  output logic [ioerb_pkg::IDX_W-1:0]   ram_rd_addr,
  input  ioerb_pkg::slot_t              ram_rd_data,
  // Results toward the output register
  output logic                          push_valid,
  input  logic                          push_ready,
  output ioerb_pkg::result_t            push_data,
  // Status
  output ioerb_pkg::status_t            status
);
  import ioerb_pkg::*;

  state_t                state;
  logic [ID_W-1:0]       expected_id;
  logic [HOLD_DEPTH-1:0] slot_valid;
  logic [CNT_W-1:0]      held_count;
  logic                  mode_drain;
  slot_t                 pend;
  slot_t                 hold;
  logic [NCNT_W-1:0]     n_cnt;
  logic [CNT_W-1:0]      rd_idx;
  logic                  cmp_vld;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  logic [ID_W-1:0]       diff;
  logic                  in_order;
  logic                  newer;
  logic [ID_W-1:0]       target;
  logic                  rd_issue;
  logic                  cmp_match;
  logic                  cmp_free;
  logic                  scan_end;
  logic                  free_sel_found;
  logic [IDX_W-1:0]      free_sel_idx;

  // Classify the arriving event against the expected id
  always_comb begin
    diff     = in_event.id - expected_id;
    in_order = (in_event.id == expected_id);
    newer    = ((diff != '0) && !diff[ID_W-1])
            || ((diff == HALF_RANGE) && (in_event.id > expected_id));
  end

  // Shared comparator and scan pipeline
  always_comb begin
    target         = mode_drain ? expected_id : pend.id;
    rd_issue       = (state == ST_SCAN) && (rd_idx < CNT_W'(HOLD_DEPTH));
    cmp_match      = cmp_vld && slot_valid[cmp_idx] && (ram_rd_data.id == target);
    cmp_free       = cmp_vld && !slot_valid[cmp_idx];
    scan_end       = cmp_vld && (cmp_idx == IDX_W'(HOLD_DEPTH - 1));
    free_sel_found = free_found || cmp_free;
    free_sel_idx   = free_found ? free_idx : cmp_idx;
  end

  // Store ports
  assign ram_rd_en   = rd_issue;
  assign ram_rd_addr = rd_idx[IDX_W-1:0];
  assign ram_wr_en   = (state == ST_SCAN) && !mode_drain && !cmp_match
                    && scan_end && free_sel_found;
  assign ram_wr_addr = free_sel_idx;
  assign ram_wr_data = pend;

  // Handshakes
  assign in_ready    = (state == ST_IDLE);
  assign push_valid  = (state == ST_PUSH) || (state == ST_LAST);
  assign push_data   = '{last:   (state == ST_LAST),
                         id:     pend.id,
                         handle: pend.handle,
                         kind:   pend.kind};

  assign status = '{expected_id: expected_id,
                    held_count:  held_count,
                    slot_valid:  slot_valid};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      expected_id <= '0;
      slot_valid  <= '0;
      held_count  <= '0;
      mode_drain  <= 1'b0;
      n_cnt       <= '0;
      rd_idx      <= '0;
      cmp_vld     <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pend       <= in_event;
            rd_idx     <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            if (in_order) begin
              expected_id <= in_event.id + ID_W'(1);
              n_cnt       <= NCNT_W'(1);
              mode_drain  <= 1'b1;
              if ((held_count == '0) || (MAX_RESULTS == 1)) begin
                state <= ST_LAST;
              end else begin
                state <= ST_SCAN;
              end
            end else if (newer && (held_count != CNT_W'(HOLD_DEPTH))) begin
              mode_drain <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          cmp_vld <= rd_issue;
          cmp_idx <= rd_idx[IDX_W-1:0];
          if (rd_issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          // Remember the lowest free slot
          if (cmp_free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (cmp_match) begin
            if (mode_drain) begin
              // Next event of the run found: take it out of the store
              hold                <= ram_rd_data;
              slot_valid[cmp_idx] <= 1'b0;
              held_count          <= held_count - CNT_W'(1);
              expected_id         <= expected_id + ID_W'(1);
              n_cnt               <= n_cnt + NCNT_W'(1);
              state               <= ST_PUSH;
            end else begin
              // Id already held: drop
              state <= ST_IDLE;
            end
          end else if (scan_end) begin
            if (mode_drain) begin
              state <= ST_LAST;
            end else begin
              if (free_sel_found) begin
                slot_valid[free_sel_idx] <= 1'b1;
                held_count               <= held_count + CNT_W'(1);
              end
              state <= ST_IDLE;
            end
          end
        end

        ST_PUSH: begin
          if (push_ready) begin
            pend    <= hold;
            rd_idx  <= '0;
            cmp_vld <= 1'b0;
            if ((n_cnt == NCNT_W'(MAX_RESULTS)) || (held_count == '0)) begin
              state <= ST_LAST;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        ST_LAST: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/in_order_event_reorder_buffer.sv */
// ---------------------------------------------------------------------------
// in_order_event_reorder_buffer
// Delivers reliable events strictly in id order, holding early arrivals in a
// slot store that one sequencer scans through a shared id comparator.
// ---------------------------------------------------------------------------
// An in-order event with nothing held is accepted, passes through ST_LAST and
//   then the output register; no new event is taken until its result is pushed.
// Each store lookup scans one slot per cycle through the read port: one scan
//   for a held (newer) event, and one more scan for every held event drained
//   after an in-order arrival.
// Reset: expected id 0, store empty by its valid bits, no clearing pass.
module in_order_event_reorder_buffer (
  input  logic        clk,
  input  logic        rst,
  // Input events
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // event_id[15:0], event_kind[23:16],
                                      // payload_handle[39:24]
  // Delivered events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_kind[7:0], out_handle[23:8],
                                      // out_id[39:24]
  output logic        m_axis_tlast    // last_of_run
);
  import ioerb_pkg::*;

  slot_t            in_event;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  slot_t            ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  slot_t            ram_rd_data;
  logic             push_valid;
  logic             push_ready;
  result_t          push_data;
  status_t          status;
  result_t          out_reg;

  // Unpack the input transfer
  assign in_event = '{handle: s_axis_tdata[39:24],
                      kind:   s_axis_tdata[23:16],
                      id:     s_axis_tdata[15:0]};

  ioerb_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_event    (in_event),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .status      (status)
  );

  ioerb_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register
  assign push_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push_ready) begin
      m_axis_tvalid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      out_reg <= push_data;
    end
  end

  assign m_axis_tdata = {out_reg.id, out_reg.handle, out_reg.kind};
  assign m_axis_tlast = out_reg.last;

`ifndef SYNTHESIS
  // Fill count tracks the valid bits
  a_held_count: assert property (@(posedge clk) disable iff (rst)
    status.held_count == CNT_W'($countones(status.slot_valid)))
    else $error("held count does not match valid slots");

  // No input is taken while a result is being pushed
  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && push_valid))
    else $error("input ready while results pending");

  // An in-order event advances the expected id by one
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata[15:0] == status.expected_id))
    |=> (status.expected_id == $past(s_axis_tdata[15:0]) + 16'd1))
    else $error("expected id did not advance");
`endif

endmodule
